@@ rtl/vt4_pkg.sv @@
// Shared constants, types and reset values for the 4x4 vertex transform.
package vt4_pkg;

  // Fixed-point format of coordinates and coefficients.
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Port field widths.
  localparam int FIELD_W   = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 8;
  localparam int HALF_W    = 32;

  localparam int LANES    = 4;
  localparam int COLS     = 4;
  localparam int NUM_REGS = 8;

  // Vector operand must also hold the implied w of one in point mode.
  localparam int VEC_W  = (COORD_WIDTH > FRAC_BITS + 1) ? COORD_WIDTH : FRAC_BITS + 2;
  localparam int PROD_W = COORD_WIDTH + VEC_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [VEC_W-1:0]       vec_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [PAIR_W-1:0]      pair_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  // Vertex mode codes.
  localparam logic MODE_POINT  = 1'b0;
  localparam logic MODE_VECTOR = 1'b1;

  localparam vec_t W_ONE = vec_t'(1) << FRAC_BITS;

  localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Identity matrix.
  localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  // Per-stage load enables for a lane.
  typedef struct packed {
    logic en_mul;
    logic en_pair;
    logic en_sum;
    logic en_sat;
  } lane_ctrl_t;

  // What one lane found for its row.
  typedef struct packed {
    logic [COORD_WIDTH-1:0] value;
    logic                   ovf;
  } lane_res_t;

endpackage

@@ rtl/vt4_if.sv @@
// Channel interfaces: vertex input, transformed result, configuration write.
interface vt4_vertex_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [vt4_pkg::FIELD_W-1:0] in_x;
  logic [vt4_pkg::FIELD_W-1:0] in_y;
  logic [vt4_pkg::FIELD_W-1:0] in_z;
  logic [vt4_pkg::FIELD_W-1:0] in_w;

  modport source (output valid, mode, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, mode, in_x, in_y, in_z, in_w, output ready);
endinterface

interface vt4_result_if;
  logic                       valid;
  logic                       ready;
  logic [vt4_pkg::FIELD_W-1:0] out_x;
  logic [vt4_pkg::FIELD_W-1:0] out_y;
  logic [vt4_pkg::FIELD_W-1:0] out_z;
  logic [vt4_pkg::FIELD_W-1:0] out_w;
  logic                       overflow;

  modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface

interface vt4_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [vt4_pkg::CFG_IDX_W-1:0] index;
  logic [vt4_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/vt4_lane.sv @@
// One matrix row: four products, adder tree, shift and saturation.
module vt4_lane (
  input  logic                clk,
  input  vt4_pkg::lane_ctrl_t ctrl,
  input  vt4_pkg::coord_t     coef [vt4_pkg::COLS],
  input  vt4_pkg::vec_t       vec  [vt4_pkg::COLS],
  output vt4_pkg::lane_res_t  result
);

  vt4_pkg::prod_t prod [vt4_pkg::COLS];
  vt4_pkg::pair_t pair [2];
  vt4_pkg::sum_t  sum;
  vt4_pkg::sum_t  shifted;
  logic [vt4_pkg::SUM_W-vt4_pkg::COORD_WIDTH:0] upper;
  logic           sat;

  always_ff @(posedge clk) begin
    if (ctrl.en_mul) begin
      for (int c = 0; c < vt4_pkg::COLS; c++) begin
        prod[c] <= coef[c] * vec[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_pair) begin
      pair[0] <= vt4_pkg::pair_t'(prod[0]) + vt4_pkg::pair_t'(prod[1]);
      pair[1] <= vt4_pkg::pair_t'(prod[2]) + vt4_pkg::pair_t'(prod[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_sum) begin
      sum <= vt4_pkg::sum_t'(pair[0]) + vt4_pkg::sum_t'(pair[1]);
    end
  end

  // Floor shift; in range only if all bits above the sign agree with it.
  always_comb begin
    shifted = sum >>> vt4_pkg::FRAC_BITS;
    upper   = shifted[vt4_pkg::SUM_W-1:vt4_pkg::COORD_WIDTH-1];
    sat     = !((&upper) || !(|upper));
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_sat) begin
      result.ovf <= sat;
      if (sat) begin
        result.value <= shifted[vt4_pkg::SUM_W-1] ? vt4_pkg::SAT_MIN : vt4_pkg::SAT_MAX;
      end else begin
        result.value <= shifted[vt4_pkg::COORD_WIDTH-1:0];
      end
    end
  end

endmodule

@@ rtl/vt4_merge.sv @@
// Output register: gathers the four lanes into one result and ORs overflow.
module vt4_merge (
  input  logic                         clk,
  input  logic                         en,
  input  vt4_pkg::lane_res_t           lanes [vt4_pkg::LANES],
  output logic [vt4_pkg::FIELD_W-1:0]  out_x,
  output logic [vt4_pkg::FIELD_W-1:0]  out_y,
  output logic [vt4_pkg::FIELD_W-1:0]  out_z,
  output logic [vt4_pkg::FIELD_W-1:0]  out_w,
  output logic                         overflow
);

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= vt4_pkg::FIELD_W'($signed(lanes[0].value));
      out_y    <= vt4_pkg::FIELD_W'($signed(lanes[1].value));
      out_z    <= vt4_pkg::FIELD_W'($signed(lanes[2].value));
      out_w    <= vt4_pkg::FIELD_W'($signed(lanes[3].value));
      overflow <= lanes[0].ovf | lanes[1].ovf | lanes[2].ovf | lanes[3].ovf;
    end
  end

endmodule

@@ rtl/vertex_transform_4x4_unit.sv @@
// Top level of the 4x4 homogeneous matrix-vector transform unit.
//
// Usage:
//   cfg : write channel for the eight 64-bit matrix registers, two Q16.16
//         coefficients each (low half even column, high half odd column).
//         Always ready; writes to an index above seven are dropped.
//         Write only while no vertex is in flight.
//   vtx : one vertex per transaction, mode selects point (w = 1) or vector.
//   res : four saturated Q16.16 components plus an overflow flag.
//
// Four row lanes run side by side, each a four-stage pipe (multiply, pair
// add, final add, shift and saturate), followed by a merge stage that is
// also the output register. The accepting edge loads the multiply stage,
// and res.valid rises when that vertex reaches the merge stage; throughput
// is one vertex per cycle while res.ready is high (parallel per-row multipliers).
//
// Reset loads the identity matrix and empties the pipe. When the receiver
// stalls, each stage holds only while every stage after it is full, so bubbles close
// up and vtx.ready drops only once all five stages are occupied.
module vertex_transform_4x4_unit (
  input logic          clk,
  input logic          rst,
  vt4_cfg_if.sink      cfg,
  vt4_vertex_if.sink   vtx,
  vt4_result_if.source res
);

  localparam int STAGES = 5;

  logic [vt4_pkg::CFG_W-1:0] mat_regs [vt4_pkg::NUM_REGS];

  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] stage_ready;

  vt4_pkg::lane_ctrl_t lane_ctrl;
  vt4_pkg::coord_t     coef [vt4_pkg::LANES][vt4_pkg::COLS];
  vt4_pkg::vec_t       vec  [vt4_pkg::COLS];
  vt4_pkg::lane_res_t  lane_out [vt4_pkg::LANES];

  // Matrix registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vt4_pkg::NUM_REGS; i++) begin
        mat_regs[i] <= vt4_pkg::REG_RESET[i];
      end
    end else if (cfg.valid && cfg.ready &&
                 (cfg.index < vt4_pkg::CFG_IDX_W'(vt4_pkg::NUM_REGS))) begin
      mat_regs[cfg.index[$clog2(vt4_pkg::NUM_REGS)-1:0]] <= cfg.data;
    end
  end

  // Coefficient m[r][c] lives in register 2r + c/2, half c%2.
  for (genvar r = 0; r < vt4_pkg::LANES; r++) begin : g_coef
    for (genvar c = 0; c < vt4_pkg::COLS; c++) begin : g_col
      assign coef[r][c] =
        mat_regs[2*r + c/2][(c%2)*vt4_pkg::HALF_W +: vt4_pkg::COORD_WIDTH];
    end
  end

  // Vertex operands, low COORD_WIDTH bits sign extended; point mode uses w = 1.
  always_comb begin
    vec[0] = vt4_pkg::vec_t'($signed(vtx.in_x[vt4_pkg::COORD_WIDTH-1:0]));
    vec[1] = vt4_pkg::vec_t'($signed(vtx.in_y[vt4_pkg::COORD_WIDTH-1:0]));
    vec[2] = vt4_pkg::vec_t'($signed(vtx.in_z[vt4_pkg::COORD_WIDTH-1:0]));
    if (vtx.mode == vt4_pkg::MODE_VECTOR) begin
      vec[3] = vt4_pkg::vec_t'($signed(vtx.in_w[vt4_pkg::COORD_WIDTH-1:0]));
    end else begin
      vec[3] = vt4_pkg::W_ONE;
    end
  end

  // Per-stage flow control: a stage loads when empty or when the next moves.
  always_comb begin
    stage_ready[STAGES-1] = !stage_valid[STAGES-1] || res.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        stage_valid[0] <= vtx.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (stage_ready[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  assign vtx.ready = stage_ready[0];
  assign res.valid = stage_valid[STAGES-1];

  assign lane_ctrl.en_mul  = stage_ready[0];
  assign lane_ctrl.en_pair = stage_ready[1];
  assign lane_ctrl.en_sum  = stage_ready[2];
  assign lane_ctrl.en_sat  = stage_ready[3];

  for (genvar r = 0; r < vt4_pkg::LANES; r++) begin : g_lane
    vt4_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .coef   (coef[r]),
      .vec    (vec),
      .result (lane_out[r])
    );
  end

  vt4_merge u_merge (
    .clk      (clk),
    .en       (stage_ready[STAGES-1]),
    .lanes    (lane_out),
    .out_x    (res.out_x),
    .out_y    (res.out_y),
    .out_z    (res.out_z),
    .out_w    (res.out_w),
    .overflow (res.overflow)
  );

`ifndef SYNTHESIS
  // An accepted vertex always lands in the multiply stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    vtx.valid && vtx.ready |=> stage_valid[0])
    else $error("accepted vertex lost at pipe entry");

  // Overflow flag only with at least one saturated component.
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.overflow |->
      (res.out_x[vt4_pkg::COORD_WIDTH-1:0] == vt4_pkg::SAT_MAX) ||
      (res.out_x[vt4_pkg::COORD_WIDTH-1:0] == vt4_pkg::SAT_MIN) ||
      (res.out_y[vt4_pkg::COORD_WIDTH-1:0] == vt4_pkg::SAT_MAX) ||
      (res.out_y[vt4_pkg::COORD_WIDTH-1:0] == vt4_pkg::SAT_MIN) ||
      (res.out_z[vt4_pkg::COORD_WIDTH-1:0] == vt4_pkg::SAT_MAX) ||
      (res.out_z[vt4_pkg::COORD_WIDTH-1:0] == vt4_pkg::SAT_MIN) ||
      (res.out_w[vt4_pkg::COORD_WIDTH-1:0] == vt4_pkg::SAT_MAX) ||
      (res.out_w[vt4_pkg::COORD_WIDTH-1:0] == vt4_pkg::SAT_MIN))
    else $error("overflow set without a saturated component");

  // Input is refused only when every stage holds a vertex.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !vtx.ready |-> (&stage_valid) && !res.ready)
    else $error("input stalled with room in the pipe");
`endif

endmodule

@@ tb/vertex_transform_4x4_unit_tb.sv @@
// Testbench for vertex_transform_4x4_unit: directed table, then random checked vertices.
`timescale 1ns / 1ps

module vertex_transform_4x4_unit_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int BLOCKS       = 12;
  localparam int BLOCK_ITEMS  = 120;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 12;

  localparam logic [vt4_pkg::FIELD_W-1:0] Q_MAX   = 32'h7fff_ffff;
  localparam logic [vt4_pkg::FIELD_W-1:0] Q_MIN   = 32'h8000_0000;
  localparam logic [vt4_pkg::FIELD_W-1:0] Q_NEG1  = 32'hffff_ffff;
  localparam logic [vt4_pkg::FIELD_W-1:0] Q_LSB   = 32'h0000_0001;
  localparam logic [vt4_pkg::FIELD_W-1:0] Q_ONE   = 32'h0001_0000;
  localparam logic [vt4_pkg::FIELD_W-1:0] Q_TWO   = 32'h0002_0000;
  localparam logic [vt4_pkg::FIELD_W-1:0] Q_THREE = 32'h0003_0000;

  // Matrix register map; anything from REG_UNUSED_LO up is not decoded.
  typedef enum logic [vt4_pkg::CFG_IDX_W-1:0] {
    REG_ROW0_C01, REG_ROW0_C23, REG_ROW1_C01, REG_ROW1_C23,
    REG_ROW2_C01, REG_ROW2_C23, REG_ROW3_C01, REG_ROW3_C23,
    REG_UNUSED_LO,
    REG_UNUSED_HI = {vt4_pkg::CFG_IDX_W{1'b1}}
  } mat_reg_e;

  typedef enum logic [1:0] {ROW_VTX, ROW_REG, ROW_FILL} row_kind_e;

  typedef struct packed {
    logic                        mode;
    logic [vt4_pkg::FIELD_W-1:0] x, y, z, w;
  } vtx_item_t;

  typedef struct packed {
    logic [vt4_pkg::FIELD_W-1:0] x, y, z, w;
    logic                        ovf;
  } xf_result_t;

  typedef struct packed {
    logic       typed;
    xf_result_t want;
  } typed_want_t;

  typedef struct packed {
    row_kind_e                     kind;
    logic [vt4_pkg::CFG_IDX_W-1:0] idx;
    logic [vt4_pkg::CFG_W-1:0]     val;
    vtx_item_t                     item;
    logic                          typed;
    xf_result_t                    want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  vt4_cfg_if    cfg_bus ();
  vt4_vertex_if vtx_bus ();
  vt4_result_if res_bus ();

  vertex_transform_4x4_unit dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .vtx (vtx_bus),
    .res (res_bus)
  );

  // Shadow of the matrix registers, updated from observed config transactions.
  logic [vt4_pkg::CFG_W-1:0] mat_shadow [vt4_pkg::NUM_REGS];

  xf_result_t  expected_xf [$];   // transformed vertices still owed by the DUT
  typed_want_t typed_wants [$];   // per driven vertex: hand-typed answer, if any

  int n_sent        = 0;
  int n_checked     = 0;
  int n_fail        = 0;
  int tx_idle_pct   = 20;
  int rx_idle_pct   = 45;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Fixed-point M * v with floor shift and saturation per row.
  function automatic xf_result_t transform_vertex(input vtx_item_t it);
    vt4_pkg::sum_t                   vin [vt4_pkg::COLS];
    vt4_pkg::sum_t                   acc;
    vt4_pkg::sum_t                   hi;
    vt4_pkg::sum_t                   lo;
    logic [vt4_pkg::CFG_W-1:0]       rg;
    logic [vt4_pkg::HALF_W-1:0]      half;
    logic [vt4_pkg::COORD_WIDTH-1:0] lane [vt4_pkg::LANES];
    xf_result_t                      res;
    hi = vt4_pkg::sum_t'(vt4_pkg::coord_t'(vt4_pkg::SAT_MAX));
    lo = vt4_pkg::sum_t'(vt4_pkg::coord_t'(vt4_pkg::SAT_MIN));
    res = '0;
    vin[0] = vt4_pkg::sum_t'(vt4_pkg::coord_t'(it.x[vt4_pkg::COORD_WIDTH-1:0]));
    vin[1] = vt4_pkg::sum_t'(vt4_pkg::coord_t'(it.y[vt4_pkg::COORD_WIDTH-1:0]));
    vin[2] = vt4_pkg::sum_t'(vt4_pkg::coord_t'(it.z[vt4_pkg::COORD_WIDTH-1:0]));
    // point mode: w is exactly one
    vin[3] = (it.mode == vt4_pkg::MODE_VECTOR) ?
             vt4_pkg::sum_t'(vt4_pkg::coord_t'(it.w[vt4_pkg::COORD_WIDTH-1:0])) :
             (vt4_pkg::sum_t'(1) <<< vt4_pkg::FRAC_BITS);
    for (int r = 0; r < vt4_pkg::LANES; r++) begin
      acc = '0;
      for (int c = 0; c < vt4_pkg::COLS; c++) begin
        rg   = mat_shadow[r * 2 + c / 2];
        half = (c % 2) ? rg[2*vt4_pkg::HALF_W-1:vt4_pkg::HALF_W]
                       : rg[vt4_pkg::HALF_W-1:0];
        acc  = acc + vt4_pkg::sum_t'(vt4_pkg::coord_t'(half[vt4_pkg::COORD_WIDTH-1:0]))
                     * vin[c];
      end
      acc = acc >>> vt4_pkg::FRAC_BITS;   // rounds toward minus infinity
      if (acc > hi) begin
        lane[r] = vt4_pkg::SAT_MAX;
        res.ovf = 1'b1;
      end else if (acc < lo) begin
        lane[r] = vt4_pkg::SAT_MIN;
        res.ovf = 1'b1;
      end else begin
        lane[r] = acc[vt4_pkg::COORD_WIDTH-1:0];
      end
    end
    res.x = vt4_pkg::FIELD_W'(vt4_pkg::coord_t'(lane[0]));
    res.y = vt4_pkg::FIELD_W'(vt4_pkg::coord_t'(lane[1]));
    res.z = vt4_pkg::FIELD_W'(vt4_pkg::coord_t'(lane[2]));
    res.w = vt4_pkg::FIELD_W'(vt4_pkg::coord_t'(lane[3]));
    return res;
  endfunction

  // Mostly mid-range values, some full-width, some extremes.
  function automatic logic [vt4_pkg::FIELD_W-1:0] rand_q(input int min_shift);
    logic signed [vt4_pkg::FIELD_W-1:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return '0;
          3:       return Q_NEG1;
          default: return Q_LSB;
        endcase
      end
      1, 2:    return r;
      default: return r >>> $urandom_range(24, min_shift);
    endcase
  endfunction

  function automatic dir_row_t vtx_row(input logic mode,
                                       input logic [vt4_pkg::FIELD_W-1:0] x, y, z, w);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_VTX;
    row.item = {mode, x, y, z, w};
    return row;
  endfunction

  function automatic dir_row_t vtx_row_known(input logic mode,
                                             input logic [vt4_pkg::FIELD_W-1:0] x, y, z, w,
                                             input logic [vt4_pkg::FIELD_W-1:0] ex, ey, ez, ew,
                                             input logic eo);
    dir_row_t row;
    row       = vtx_row(mode, x, y, z, w);
    row.typed = 1'b1;
    row.want  = {ex, ey, ez, ew, eo};
    return row;
  endfunction

  function automatic dir_row_t reg_row(input row_kind_e kind,
                                       input logic [vt4_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [vt4_pkg::CFG_W-1:0] val);
    dir_row_t row;
    row      = '0;
    row.kind = kind;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  task automatic check_field(input string name,
                             input logic [vt4_pkg::FIELD_W-1:0] want, got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      n_fail++;
    end
  endtask

  // Offer one vertex, possibly after a random gap; returns on the accepting edge
  // with valid still high so back-to-back transactions need no re-raise.
  task automatic drive_vertex(input vtx_item_t it, input logic typed, input xf_result_t want);
    if ($urandom_range(99) < tx_idle_pct) begin
      vtx_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    typed_wants.push_back({typed, want});
    vtx_bus.valid <= 1'b1;
    vtx_bus.mode  <= it.mode;
    vtx_bus.in_x  <= it.x;
    vtx_bus.in_y  <= it.y;
    vtx_bus.in_z  <= it.z;
    vtx_bus.in_w  <= it.w;
    do @(posedge clk); while (!vtx_bus.ready);
    n_sent++;
  endtask

  // Leaves valid high; the caller drops it after the last write of a batch.
  task automatic write_reg(input logic [vt4_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vt4_pkg::CFG_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // Pipe is empty once every accepted vertex has come back.
  task automatic wait_idle();
    vtx_bus.valid <= 1'b0;
    while (n_checked != n_sent) @(posedge clk);
  endtask

  // Receiver: random back-pressure, plus long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_bus.ready <= 1'b0;
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Scoreboard: results first, then config, then new vertices, all on one edge.
  always @(posedge clk) begin : scoreboard
    xf_result_t  want;
    typed_want_t note;
    vtx_item_t   seen;
    if (rst) begin
      mat_shadow = vt4_pkg::REG_RESET;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_xf.size() == 0) begin
          $error("result transaction with no vertex outstanding");
          n_fail++;
        end else begin
          want = expected_xf.pop_front();
          check_field("out_x", want.x, res_bus.out_x);
          check_field("out_y", want.y, res_bus.out_y);
          check_field("out_z", want.z, res_bus.out_z);
          check_field("out_w", want.w, res_bus.out_w);
          check_field("overflow", vt4_pkg::FIELD_W'(want.ovf),
                      vt4_pkg::FIELD_W'(res_bus.overflow));
          n_checked++;
        end
      end
      if (cfg_bus.valid && cfg_bus.ready && cfg_bus.index < vt4_pkg::NUM_REGS)
        mat_shadow[cfg_bus.index[$clog2(vt4_pkg::NUM_REGS)-1:0]] = cfg_bus.data;
      if (vtx_bus.valid && vtx_bus.ready) begin
        note = typed_wants.pop_front();
        seen = {vtx_bus.mode, vtx_bus.in_x, vtx_bus.in_y, vtx_bus.in_z, vtx_bus.in_w};
        expected_xf.push_back(note.typed ? note.want : transform_vertex(seen));
      end
    end
  end

  initial begin
    dir_row_t  rows [$];
    vtx_item_t it;

    rst           <= 1'b1;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data  <= '0;
    vtx_bus.valid <= 1'b0;
    vtx_bus.mode  <= vt4_pkg::MODE_POINT;
    vtx_bus.in_x  <= '0;
    vtx_bus.in_y  <= '0;
    vtx_bus.in_z  <= '0;
    vtx_bus.in_w  <= '0;

    // Identity after reset: point gets w = 1, vector passes through,
    // w ignored in point mode.
    rows.push_back(vtx_row_known(vt4_pkg::MODE_POINT, Q_ONE, Q_TWO, Q_THREE, '0,
                                 Q_ONE, Q_TWO, Q_THREE, Q_ONE, 1'b0));
    rows.push_back(vtx_row_known(vt4_pkg::MODE_VECTOR, Q_MAX, Q_MIN, '0, Q_NEG1,
                                 Q_MAX, Q_MIN, '0, Q_NEG1, 1'b0));
    rows.push_back(vtx_row_known(vt4_pkg::MODE_POINT, Q_NEG1, Q_MAX, Q_MIN, Q_MAX,
                                 Q_NEG1, Q_MAX, Q_MIN, Q_ONE, 1'b0));
    rows.push_back(vtx_row_known(vt4_pkg::MODE_VECTOR, '0, '0, '0, '0,
                                 '0, '0, '0, '0, 1'b0));
    // Largest positive coefficients: saturate high and low.
    rows.push_back(reg_row(ROW_FILL, REG_ROW0_C01, {Q_MAX, Q_MAX}));
    rows.push_back(vtx_row_known(vt4_pkg::MODE_VECTOR, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                 vt4_pkg::SAT_MAX, vt4_pkg::SAT_MAX,
                                 vt4_pkg::SAT_MAX, vt4_pkg::SAT_MAX, 1'b1));
    rows.push_back(vtx_row_known(vt4_pkg::MODE_VECTOR, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                 vt4_pkg::SAT_MIN, vt4_pkg::SAT_MIN,
                                 vt4_pkg::SAT_MIN, vt4_pkg::SAT_MIN, 1'b1));
    rows.push_back(vtx_row_known(vt4_pkg::MODE_POINT, Q_MIN, Q_MIN, Q_MIN, '0,
                                 vt4_pkg::SAT_MIN, vt4_pkg::SAT_MIN,
                                 vt4_pkg::SAT_MIN, vt4_pkg::SAT_MIN, 1'b1));
    // Most negative coefficients times most negative vertex: largest exact sum.
    rows.push_back(reg_row(ROW_FILL, REG_ROW0_C01, {Q_MIN, Q_MIN}));
    rows.push_back(vtx_row_known(vt4_pkg::MODE_VECTOR, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                 vt4_pkg::SAT_MAX, vt4_pkg::SAT_MAX,
                                 vt4_pkg::SAT_MAX, vt4_pkg::SAT_MAX, 1'b1));
    rows.push_back(vtx_row_known(vt4_pkg::MODE_VECTOR, '0, '0, '0, '0,
                                 '0, '0, '0, '0, 1'b0));
    // Half and one-lsb coefficients on row zero: floor rounding of negative sums.
    rows.push_back(reg_row(ROW_REG, REG_ROW0_C01, 64'hffff_8000_0000_8000));
    rows.push_back(reg_row(ROW_REG, REG_ROW0_C23, 64'hffff_ffff_0000_0001));
    rows.push_back(vtx_row(vt4_pkg::MODE_VECTOR, Q_NEG1, Q_LSB, '0, '0));
    rows.push_back(vtx_row(vt4_pkg::MODE_VECTOR, Q_NEG1, '0, Q_LSB, Q_NEG1));
    rows.push_back(vtx_row(vt4_pkg::MODE_VECTOR, Q_LSB, Q_NEG1, Q_MAX, Q_MIN));
    rows.push_back(vtx_row(vt4_pkg::MODE_POINT, 32'h1234_5678, 32'hedcb_a988,
                           32'h0000_8000, '0));
    // Writes past the last register must leave the matrix alone.
    rows.push_back(reg_row(ROW_REG, REG_UNUSED_LO, '1));
    rows.push_back(reg_row(ROW_REG, REG_UNUSED_HI, 64'h5555_aaaa_5555_aaaa));
    rows.push_back(vtx_row(vt4_pkg::MODE_VECTOR, Q_ONE, Q_NEG1, Q_TWO, 32'hfffe_0000));
    // Only the last row saturates.
    rows.push_back(reg_row(ROW_FILL, REG_ROW0_C01, '0));
    rows.push_back(reg_row(ROW_REG, REG_ROW3_C01, {Q_MAX, Q_MAX}));
    rows.push_back(reg_row(ROW_REG, REG_ROW0_C01, {32'h0, Q_ONE}));
    rows.push_back(vtx_row_known(vt4_pkg::MODE_VECTOR, Q_MAX, Q_MAX, 32'h5, 32'h6,
                                 Q_MAX, '0, '0, vt4_pkg::SAT_MAX, 1'b1));
    rows.push_back(vtx_row_known(vt4_pkg::MODE_VECTOR, Q_MIN, Q_MIN, '0, '0,
                                 Q_MIN, '0, '0, vt4_pkg::SAT_MIN, 1'b1));
    rows.push_back(vtx_row_known(vt4_pkg::MODE_VECTOR, Q_LSB, Q_NEG1, '0, '0,
                                 Q_LSB, '0, '0, '0, 1'b0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      case (rows[k].kind)
        ROW_VTX: drive_vertex(rows[k].item, rows[k].typed, rows[k].want);
        ROW_REG: begin
          wait_idle();
          write_reg(rows[k].idx, rows[k].val);
          cfg_bus.valid <= 1'b0;
          @(posedge clk);
        end
        default: begin
          wait_idle();
          for (int r = 0; r < vt4_pkg::NUM_REGS; r++)
            write_reg(vt4_pkg::CFG_IDX_W'(r), rows[k].val);
          cfg_bus.valid <= 1'b0;
          @(posedge clk);
        end
      endcase
    end

    // Random blocks, a fresh matrix each; idling profile switches by thirds.
    for (int b = 0; b < BLOCKS; b++) begin
      wait_idle();
      if (b == BLOCKS / 3) begin
        tx_idle_pct = 45;
        rx_idle_pct = 20;
      end else if (b == 2 * BLOCKS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int r = 0; r < vt4_pkg::NUM_REGS; r++)
        write_reg(vt4_pkg::CFG_IDX_W'(r), {rand_q(12), rand_q(12)});
      if ($urandom_range(1))
        write_reg(vt4_pkg::CFG_IDX_W'($urandom_range((1 << vt4_pkg::CFG_IDX_W) - 1,
                                                     REG_UNUSED_LO)),
                  {$urandom, $urandom});
      cfg_bus.valid <= 1'b0;
      // long receiver hold-off: pipe fills and vtx.ready must drop
      if (b == 1 || b == 2 * BLOCKS / 3) hold_requests++;
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        it.mode = $urandom_range(1) ? vt4_pkg::MODE_VECTOR : vt4_pkg::MODE_POINT;
        it.x    = rand_q(6);
        it.y    = rand_q(6);
        it.z    = rand_q(6);
        it.w    = rand_q(6);
        drive_vertex(it, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && expected_xf.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/vt4_pkg.sv
rtl/vt4_if.sv
rtl/vt4_lane.sv
rtl/vt4_merge.sv
rtl/vertex_transform_4x4_unit.sv
tb/vertex_transform_4x4_unit_tb.sv
